@@ hw/rtl/lrbg_pkg.sv @@
// ----------------------------------------------------------------------------
// lrbg_pkg: shared types and constants for the level-gated log ring buffer
// Opcodes, register indexes, controller states, field widths and the
// special characters used by the read path.
// ----------------------------------------------------------------------------
package lrbg_pkg;

  // Default sizing of the byte store and the read burst limit
  localparam int DEFAULT_DEPTH_BITS = 10;
  localparam int DEFAULT_MAX_READ   = 32;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int LEVEL_W  = 8;
  localparam int BUDGET_W = 6;
  localparam int FILL_W   = 11;
  localparam int OVF_W    = 32;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Special characters
  localparam logic [BYTE_W-1:0] CHAR_QMARK = 8'h3F;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_THRESHOLD = 1'b0,
    CFG_CRLF_MODE       = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

endpackage

@@ hw/rtl/lrbg_ram.sv @@
// ----------------------------------------------------------------------------
// lrbg_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module lrbg_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/log_ring_buffer_level_gated_core.sv @@
// ----------------------------------------------------------------------------
// log_ring_buffer_level_gated_core: level-gated byte log FIFO
// Put, read and clear requests on a valid/stall input channel; results on a
// valid/stall output channel, one result per put, clear or unused opcode,
// one per emitted byte for a read, one with no byte when a read emits none.
//
// Usage:
//   - Requests are taken when in_valid_i is high and in_stall_o is low.
//     Results leave through a one-entry output register when out_valid_o is
//     high and out_stall_i is low; a new request is taken in the same cycle
//     that the pending result is taken.
//   - Put, clear and unused opcodes present their result in the cycle after
//     the request is taken. Back-to-back puts run at one per cycle while the
//     output is not stalled.
//   - A read first fetches from the byte store, then emits one byte per
//     cycle while the output is not stalled. A LF in CRLF mode is emitted
//     as two results (CR, then LF). No new request is taken until the last
//     result of a read has been loaded.
//   - A stalled output holds every field and halts the read sequencer.
//   - Configuration writes (cfg_we_i) are to be made only while the block
//     is idle; the block itself does not enforce this.
//   - Reset clears the pointers, overflow counter and control registers,
//     not the result payload; clear resets just the pointers. The store is not
//     swept: only entries written since the last reset or clear are read back.
module log_ring_buffer_level_gated_core #(
  parameter int DEPTH_BITS = lrbg_pkg::DEFAULT_DEPTH_BITS,
  parameter int MAX_READ   = lrbg_pkg::DEFAULT_MAX_READ
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [lrbg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lrbg_pkg::CFG_W-1:0]           cfg_data_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           opcode_i,
  input  logic [lrbg_pkg::BYTE_W-1:0]          char_in_i,
  input  logic signed [lrbg_pkg::LEVEL_W-1:0]  msg_level_i,
  input  logic [lrbg_pkg::BUDGET_W-1:0]        read_budget_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lrbg_pkg::BYTE_W-1:0]          out_byte_o,
  output logic                                 byte_valid_o,
  output logic                                 last_o,
  output logic                                 dropped_o,
  output logic [lrbg_pkg::FILL_W-1:0]          fill_level_o,
  output logic [lrbg_pkg::OVF_W-1:0]           overflow_count_o
);

  import lrbg_pkg::*;

  localparam int PtrW      = DEPTH_BITS + 1;
  localparam int StoreSize = 1 << DEPTH_BITS;
  localparam int BudW      = $clog2(MAX_READ + 1);
  localparam int SatW      = (BudW > BUDGET_W) ? BudW : BUDGET_W;

  localparam logic [PtrW-1:0] FullLevel   = PtrW'(StoreSize);
  localparam logic [PtrW-1:0] AlmostLevel = PtrW'(StoreSize - 1);
  localparam logic [PtrW-1:0] PtrOne      = PtrW'(1);
  localparam logic [BudW-1:0] BudOne      = BudW'(1);
  localparam logic [BudW-1:0] BudTwo      = BudW'(2);
  localparam logic [SatW-1:0] BudMax      = SatW'(MAX_READ);

  // state
  state_e                     state_q, state_d;
  logic [PtrW-1:0]            wp_q, wp_d;
  logic [PtrW-1:0]            rp_q, rp_d;
  logic [OVF_W-1:0]           ovf_q, ovf_d;
  logic [BudW-1:0]            bud_q, bud_d;
  logic                       cr_done_q, cr_done_d;
  logic signed [LEVEL_W-1:0]  thr_q, thr_d;
  logic                       crlf_q, crlf_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]          out_byte_q, out_byte_d;
  logic                       byte_valid_q, byte_valid_d;
  logic                       last_q, last_d;
  logic                       dropped_q, dropped_d;
  logic [PtrW-1:0]            fill_out_q, fill_out_d;
  logic [OVF_W-1:0]           ovf_out_q, ovf_out_d;

  // control
  logic                       out_free;
  logic                       in_accept;
  logic [PtrW-1:0]            fill;
  logic                       full;
  logic                       almost_full;
  logic [SatW-1:0]            bud_in_ext;
  logic [BudW-1:0]            bud_sat;
  logic                       out_load;
  logic                       rd_start;
  logic                       rd_last;

  // memory port
  logic                       mem_we;
  logic [BYTE_W-1:0]          mem_wdata;
  logic                       mem_re;
  logic [BYTE_W-1:0]          mem_rdata;

  logic [PtrW+FILL_W-1:0]     fill_wide;

  // byte store
  lrbg_ram #(
    .Width (BYTE_W),
    .Depth (StoreSize)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q[DEPTH_BITS-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rp_d[DEPTH_BITS-1:0]),
    .rdata_o (mem_rdata)
  );

  // handshake and level helpers
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign fill        = wp_q - rp_q;
  assign full        = (fill == FullLevel);
  assign almost_full = (fill == AlmostLevel);

  // budget saturation
  assign bud_in_ext = SatW'(read_budget_i);
  assign bud_sat    = (bud_in_ext > BudMax) ? BudW'(BudMax) : BudW'(bud_in_ext);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (rd_start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free && rd_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath: pointers, counter, memory access and result generation
  always_comb begin
    logic [PtrW-1:0] fill_after;
    logic            rd_empty;

    wp_d         = wp_q;
    rp_d         = rp_q;
    ovf_d        = ovf_q;
    bud_d        = bud_q;
    cr_done_d    = cr_done_q;
    mem_we       = 1'b0;
    mem_wdata    = char_in_i;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    out_byte_d   = '0;
    byte_valid_d = 1'b0;
    last_d       = 1'b1;
    dropped_d    = 1'b0;
    rd_start     = 1'b0;
    rd_last      = 1'b0;
    fill_after   = fill;
    rd_empty     = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_load = 1'b1;
          unique case (opcode_e'(opcode_i))
            OP_PUT: begin
              if (thr_q <= msg_level_i) begin
                if (full) begin
                  ovf_d     = ovf_q + OVF_W'(1);
                  dropped_d = 1'b1;
                end else begin
                  if (almost_full) begin
                    ovf_d     = ovf_q + OVF_W'(1);
                    mem_wdata = CHAR_QMARK;
                  end
                  mem_we = 1'b1;
                  wp_d   = wp_q + PtrOne;
                end
              end
            end
            OP_READ: begin
              rd_empty = crlf_q ? ((bud_sat < BudTwo) || (fill == '0))
                                : ((bud_sat == '0) || (fill == '0));
              if (!rd_empty) begin
                // no result yet; start the sequencer with a store fetch
                out_load  = 1'b0;
                rd_start  = 1'b1;
                bud_d     = bud_sat;
                cr_done_d = 1'b0;
                mem_re    = 1'b1;
                // CRLF mode drops the byte held while the buffer is full
                if (crlf_q && full) begin
                  rp_d = rp_q + PtrOne;
                end
              end
            end
            OP_CLEAR: begin
              wp_d = '0;
              rp_d = '0;
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load     = 1'b1;
          byte_valid_d = 1'b1;
          bud_d        = bud_q - BudOne;
          if (!crlf_q) begin
            out_byte_d = full ? CHAR_QMARK : mem_rdata;
            rp_d       = rp_q + PtrOne;
            fill_after = wp_q - rp_d;
            rd_last    = (bud_d == '0) || (fill_after == '0);
          end else if ((mem_rdata == CHAR_LF) && !cr_done_q) begin
            out_byte_d = CHAR_CR;
            cr_done_d  = 1'b1;
            rd_last    = 1'b0;
          end else begin
            out_byte_d = mem_rdata;
            cr_done_d  = 1'b0;
            rp_d       = rp_q + PtrOne;
            fill_after = wp_q - rp_d;
            rd_last    = (bud_d < BudTwo) || (fill_after == '0);
          end
          last_d = rd_last;
          // fetch the next byte if the pointer advanced and this result does not end the read
          mem_re = !rd_last && (rp_d != rp_q);
        end
      end
      default: begin
      end
    endcase
  end

  // result register inputs
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);
  assign fill_out_d  = wp_d - rp_d;
  assign ovf_out_d   = ovf_d;

  // configuration writes
  always_comb begin
    thr_d  = thr_q;
    crlf_d = crlf_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEVEL_THRESHOLD: thr_d  = cfg_data_i;
        CFG_CRLF_MODE:       crlf_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      ovf_q       <= '0;
      bud_q       <= '0;
      cr_done_q   <= 1'b0;
      thr_q       <= '0;
      crlf_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      ovf_q       <= ovf_d;
      bud_q       <= bud_d;
      cr_done_q   <= cr_done_d;
      thr_q       <= thr_d;
      crlf_q      <= crlf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      last_q       <= last_d;
      dropped_q    <= dropped_d;
      fill_out_q   <= fill_out_d;
      ovf_out_q    <= ovf_out_d;
    end
  end

  // fill level is reported in a fixed-width field
  assign fill_wide = {{FILL_W{1'b0}}, fill_out_q};

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign byte_valid_o     = byte_valid_q;
  assign last_o           = last_q;
  assign dropped_o        = dropped_q;
  assign fill_level_o     = fill_wide[FILL_W-1:0];
  assign overflow_count_o = ovf_out_q;

endmodule
